>>> hw/rtl/sgalloc_pkg.sv
// ----------------------------------------------------------------------------
// Segment allocator package
// Shared command, result and status types of the allocator controller and
// datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sgalloc_pkg;

    typedef logic [3:0] cmd_code_t;

    localparam cmd_code_t CMD_NONE     = 4'd0;
    localparam cmd_code_t CMD_INIT     = 4'd1;
    localparam cmd_code_t CMD_START    = 4'd2;
    localparam cmd_code_t CMD_EV_ALLOC = 4'd3;
    localparam cmd_code_t CMD_EXACT    = 4'd4;
    localparam cmd_code_t CMD_SPLIT_N  = 4'd5;
    localparam cmd_code_t CMD_SPLIT_H  = 4'd6;
    localparam cmd_code_t CMD_EV_FREE  = 4'd7;
    localparam cmd_code_t CMD_MARK     = 4'd8;
    localparam cmd_code_t CMD_EV_NX    = 4'd9;
    localparam cmd_code_t CMD_LOAD_PV  = 4'd10;
    localparam cmd_code_t CMD_EV_PV    = 4'd11;
    localparam cmd_code_t CMD_RESULT   = 4'd12;

    typedef logic [2:0] status_code_t;

    localparam status_code_t ST_OK        = 3'd0;
    localparam status_code_t ST_NO_FIT    = 3'd1;
    localparam status_code_t ST_FULL      = 3'd2;
    localparam status_code_t ST_NOT_FOUND = 3'd3;
    localparam status_code_t ST_ZERO      = 3'd4;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_NEXT  = 2'd1;
    localparam logic [1:0] POL_BEST  = 2'd2;
    localparam logic [1:0] POL_WORST = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic CFG_ARENA  = 1'b0;
    localparam logic CFG_POLICY = 1'b1;

    typedef struct packed {
        cmd_code_t    code;
        status_code_t result;
    } dp_cmd_t;

    typedef struct packed {
        logic is_free;
        logic size_zero;
        logic scan_go;
        logic ev_stop;
        logic found;
        logic exact;
        logic spare_done;
        logic spare_none;
        logic idx_in_range;
        logic free_match;
        logic link_live;
        logic out_ready;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/segment_allocator_fit_policies_top.sv
// ----------------------------------------------------------------------------
// Segment allocator with fit policies
// Allocates and frees segments of an arena described by a linked table.
// Each input word is an allocate or a free request; each produces one output
// word with status, granted offset and the count of table entries in use.
// Both channels use valid and stall; a word moves when valid is high and
// stall is low. The configuration port writes the arena size (which also
// re-initialises the table) or the placement policy; the user must write
// it only while the block is idle, as the block does not enforce this.
// One request is handled at a time. Each table entry visited takes a check
// state and an evaluate state, as each step waits on the registered table
// read, plus dispatch, update and output states. After reset the block
// writes the initial hole before taking its first word. The output register
// lets the next request be accepted while the previous word waits; a stalled
// receiver holds the word, and a finished request then waits for it to be free.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_allocator_fit_policies_top
    import sgalloc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int OFFSET_BITS   = 24
)
(
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  wire                                 op,
    input  wire  [OFFSET_BITS-1:0]              req_bytes,
    input  wire  [OFFSET_BITS-1:0]              release_offset,
    output logic                                out_valid,
    input  wire                                 out_stall,
    output logic [2:0]                          status,
    output logic [OFFSET_BITS-1:0]              grant_offset,
    output logic [$clog2(TABLE_ENTRIES+1)-1:0]  entries_in_use,
    input  wire                                 cfg_we,
    input  wire                                 cfg_index,
    input  wire  [OFFSET_BITS-1:0]              cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sgalloc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    sgalloc_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .OFFSET_BITS   (OFFSET_BITS)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .in_op             (op),
        .in_req_bytes      (req_bytes),
        .in_release_offset (release_offset),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .out_status        (status),
        .out_grant         (grant_offset),
        .out_count         (entries_in_use)
    );

endmodule

`default_nettype wire

>>> hw/rtl/sgalloc_dp.sv
// ----------------------------------------------------------------------------
// Segment allocator datapath
// Segment table memories, valid bits, scan registers, configuration and the
// output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module sgalloc_dp
    import sgalloc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int OFFSET_BITS   = 24
)
(
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  dp_cmd_t                                 cmd,
    output dp_stat_t                                stat,
    input  wire                                     in_op,
    input  wire  [OFFSET_BITS-1:0]                  in_req_bytes,
    input  wire  [OFFSET_BITS-1:0]                  in_release_offset,
    input  wire                                     cfg_we,
    input  wire                                     cfg_index,
    input  wire  [OFFSET_BITS-1:0]                  cfg_data,
    output logic                                    out_valid,
    input  wire                                     out_stall,
    output logic [2:0]                              out_status,
    output logic [OFFSET_BITS-1:0]                  out_grant,
    output logic [$clog2(TABLE_ENTRIES+1)-1:0]      out_count
);

    localparam int OB = OFFSET_BITS;
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int LW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [LW-1:0] NONE = LW'(TABLE_ENTRIES);
    localparam logic [OB-1:0] TOP = {{(OB-2){1'b1}}, 2'b00};
    localparam logic [OB-1:0] ARENA_RST = (OB >= 13) ? OB'(4096) : TOP;

    logic [OB-1:0] start_mem [TABLE_ENTRIES];
    logic [OB-1:0] len_mem   [TABLE_ENTRIES];
    logic [LW-1:0] succ_mem  [TABLE_ENTRIES];
    logic [LW-1:0] pred_mem  [TABLE_ENTRIES];
    logic          hole_mem  [TABLE_ENTRIES];

    logic [OB-1:0] rd_start_reg;
    logic [OB-1:0] rd_len_reg;
    logic [LW-1:0] rd_succ_reg;
    logic [LW-1:0] rd_pred_reg;
    logic          rd_hole_reg;

    logic [OB-1:0]            arena_reg;
    logic [1:0]               policy_reg;
    logic                     op_reg;
    logic [OB:0]              size_reg;
    logic [OB-1:0]            off_reg;
    logic [LW-1:0]            cur_reg, cur_next;
    logic [LW-1:0]            steps_reg;
    logic [LW-1:0]            s_reg;
    logic                     h_found_reg;
    logic [LW-1:0]            h_idx_reg;
    logic [OB-1:0]            h_start_reg;
    logic [OB-1:0]            h_len_reg;
    logic [LW-1:0]            h_pred_reg;
    logic [LW-1:0]            sp_reg;
    logic [LW-1:0]            e_idx_reg;
    logic [OB-1:0]            e_len_reg;
    logic [LW-1:0]            e_succ_reg;
    logic [LW-1:0]            e_pred_reg;
    logic [LW-1:0]            head_reg;
    logic [LW-1:0]            rover_reg;
    logic [LW-1:0]            count_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic                     out_valid_reg;
    logic [2:0]               out_status_reg;
    logic [OB-1:0]            out_grant_reg;
    logic [LW-1:0]            out_count_reg;

    logic          init_go;
    logic [OB-1:0] init_len;
    logic [OB:0]   arena_sum;
    logic [OB-1:0] arena_val;
    logic [OB:0]   size_in;
    logic          fits, better, take;
    logic [LW-1:0] nx_wrap;
    logic [LW-1:0] start_pick;
    logic          load_out;

    logic          we_start, we_len, we_succ, we_pred, we_hole;
    logic [LW-1:0] wa_start, wa_len, wa_succ, wa_pred, wa_hole;
    logic [OB-1:0] wd_start, wd_len;
    logic [LW-1:0] wd_succ, wd_pred;
    logic          wd_hole;

    function automatic logic is_live(input logic [LW-1:0] l,
                                     input logic [TABLE_ENTRIES-1:0] v);
        return (l < NONE) && v[l[IW-1:0]];
    endfunction

    assign arena_sum = {1'b0, cfg_data} + (OB+1)'(3);
    assign arena_val = arena_sum[OB] ? TOP : {arena_sum[OB-1:2], 2'b00};
    assign init_go   = (cmd.code == CMD_INIT) || (cfg_we && cfg_index == CFG_ARENA);
    assign init_len  = (cfg_we && cfg_index == CFG_ARENA) ? arena_val : arena_reg;
    assign size_in   = ({1'b0, in_req_bytes} + (OB+1)'(3)) & ~(OB+1)'(3);

    assign fits    = rd_hole_reg && ({1'b0, rd_len_reg} >= size_reg);
    assign better  = !h_found_reg || (policy_reg == POL_FIRST) || (policy_reg == POL_NEXT)
                     || (policy_reg == POL_BEST && rd_len_reg < h_len_reg)
                     || (policy_reg == POL_WORST && rd_len_reg > h_len_reg);
    assign take    = fits && better;
    assign nx_wrap = (rd_succ_reg >= NONE) ? head_reg : rd_succ_reg;
    assign start_pick = is_live(rover_reg, valid_reg) ? rover_reg : head_reg;
    assign load_out = (cmd.code == CMD_RESULT);

    always_comb
    begin
        stat.is_free      = (op_reg == OP_FREE);
        stat.size_zero    = (size_reg == '0);
        stat.scan_go      = is_live(cur_reg, valid_reg) && (steps_reg < NONE);
        stat.ev_stop      = ((policy_reg == POL_FIRST || policy_reg == POL_NEXT) && fits)
                            || (policy_reg == POL_NEXT && nx_wrap == s_reg);
        stat.found        = h_found_reg;
        stat.exact        = ({1'b0, h_len_reg} == size_reg);
        stat.spare_none   = (sp_reg == NONE);
        stat.spare_done   = (sp_reg == NONE) || !valid_reg[sp_reg[IW-1:0]];
        stat.idx_in_range = (cur_reg < NONE);
        stat.free_match   = valid_reg[cur_reg[IW-1:0]] && !rd_hole_reg
                            && (rd_start_reg == off_reg);
        stat.link_live    = is_live(cur_reg, valid_reg);
        stat.out_ready    = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        we_start = 1'b0; wa_start = '0; wd_start = '0;
        we_len   = 1'b0; wa_len   = '0; wd_len   = '0;
        we_succ  = 1'b0; wa_succ  = '0; wd_succ  = '0;
        we_pred  = 1'b0; wa_pred  = '0; wd_pred  = '0;
        we_hole  = 1'b0; wa_hole  = '0; wd_hole  = 1'b0;
        if (init_go)
        begin
            we_start = 1'b1; wd_start = '0;
            we_len   = 1'b1; wd_len   = init_len;
            we_succ  = 1'b1; wd_succ  = NONE;
            we_pred  = 1'b1; wd_pred  = NONE;
            we_hole  = 1'b1; wd_hole  = 1'b1;
        end
        else
        begin
            unique case (cmd.code)
                CMD_EXACT:
                begin
                    we_hole = 1'b1; wa_hole = h_idx_reg; wd_hole = 1'b0;
                end
                CMD_SPLIT_N:
                begin
                    we_start = 1'b1; wa_start = sp_reg; wd_start = h_start_reg;
                    we_len   = 1'b1; wa_len   = sp_reg; wd_len   = size_reg[OB-1:0];
                    we_succ  = 1'b1; wa_succ  = sp_reg; wd_succ  = h_idx_reg;
                    we_pred  = 1'b1; wa_pred  = sp_reg; wd_pred  = h_pred_reg;
                    we_hole  = 1'b1; wa_hole  = sp_reg; wd_hole  = 1'b0;
                end
                CMD_SPLIT_H:
                begin
                    we_succ  = (h_pred_reg < NONE); wa_succ = h_pred_reg; wd_succ = sp_reg;
                    we_pred  = 1'b1; wa_pred  = h_idx_reg; wd_pred = sp_reg;
                    we_start = 1'b1; wa_start = h_idx_reg;
                    wd_start = h_start_reg + size_reg[OB-1:0];
                    we_len   = 1'b1; wa_len   = h_idx_reg;
                    wd_len   = h_len_reg - size_reg[OB-1:0];
                end
                CMD_MARK:
                begin
                    we_hole = 1'b1; wa_hole = e_idx_reg; wd_hole = 1'b1;
                end
                CMD_EV_NX:
                begin
                    we_len  = rd_hole_reg; wa_len  = e_idx_reg; wd_len = e_len_reg + rd_len_reg;
                    we_succ = rd_hole_reg; wa_succ = e_idx_reg; wd_succ = rd_succ_reg;
                    we_pred = rd_hole_reg && (rd_succ_reg < NONE);
                    wa_pred = rd_succ_reg; wd_pred = e_idx_reg;
                end
                CMD_EV_PV:
                begin
                    we_len  = rd_hole_reg; wa_len  = cur_reg; wd_len = rd_len_reg + e_len_reg;
                    we_succ = rd_hole_reg; wa_succ = cur_reg; wd_succ = e_succ_reg;
                    we_pred = rd_hole_reg && (e_succ_reg < NONE);
                    wa_pred = e_succ_reg; wd_pred = cur_reg;
                end
                default:
                begin
                    we_hole = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_start) start_mem[wa_start[IW-1:0]] <= wd_start;
        if (we_len)   len_mem[wa_len[IW-1:0]]     <= wd_len;
        if (we_succ)  succ_mem[wa_succ[IW-1:0]]   <= wd_succ;
        if (we_pred)  pred_mem[wa_pred[IW-1:0]]   <= wd_pred;
        if (we_hole)  hole_mem[wa_hole[IW-1:0]]   <= wd_hole;
        rd_start_reg <= start_mem[cur_reg[IW-1:0]];
        rd_len_reg   <= len_mem[cur_reg[IW-1:0]];
        rd_succ_reg  <= succ_mem[cur_reg[IW-1:0]];
        rd_pred_reg  <= pred_mem[cur_reg[IW-1:0]];
        rd_hole_reg  <= hole_mem[cur_reg[IW-1:0]];
    end

    always_comb
    begin
        cur_next = cur_reg;
        unique case (cmd.code)
            CMD_START:    cur_next = (in_op == OP_FREE) ? '0
                                     : ((policy_reg == POL_NEXT) ? start_pick : head_reg);
            CMD_EV_ALLOC: cur_next = (policy_reg == POL_NEXT) ? nx_wrap : rd_succ_reg;
            CMD_EV_FREE:  cur_next = stat.free_match ? cur_reg : cur_reg + LW'(1);
            CMD_MARK:     cur_next = e_succ_reg;
            CMD_EV_NX:    cur_next = e_pred_reg;
            CMD_LOAD_PV:  cur_next = e_pred_reg;
            default:      cur_next = cur_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.code)
            CMD_START:
            begin
                op_reg      <= in_op;
                size_reg    <= size_in;
                off_reg     <= in_release_offset;
                steps_reg   <= '0;
                s_reg       <= (policy_reg == POL_NEXT) ? start_pick : head_reg;
                h_found_reg <= 1'b0;
            end
            CMD_EV_ALLOC:
            begin
                steps_reg <= steps_reg + LW'(1);
                if (take)
                begin
                    h_found_reg <= 1'b1;
                    h_idx_reg   <= cur_reg;
                    h_start_reg <= rd_start_reg;
                    h_len_reg   <= rd_len_reg;
                    h_pred_reg  <= rd_pred_reg;
                end
            end
            CMD_EV_FREE:
            begin
                if (stat.free_match)
                begin
                    e_idx_reg  <= cur_reg;
                    e_len_reg  <= rd_len_reg;
                    e_succ_reg <= rd_succ_reg;
                    e_pred_reg <= rd_pred_reg;
                end
            end
            CMD_EV_NX:
            begin
                if (rd_hole_reg)
                begin
                    e_len_reg  <= e_len_reg + rd_len_reg;
                    e_succ_reg <= rd_succ_reg;
                end
            end
            default:
            begin
                e_idx_reg <= e_idx_reg;
            end
        endcase
        if (load_out)
        begin
            out_status_reg <= cmd.result;
            out_grant_reg  <= (cmd.result == ST_OK && op_reg == OP_ALLOC) ? h_start_reg : '0;
            out_count_reg  <= count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arena_reg     <= ARENA_RST;
            policy_reg    <= POL_FIRST;
            cur_reg       <= '0;
            sp_reg        <= '0;
            head_reg      <= '0;
            rover_reg     <= '0;
            count_reg     <= LW'(1);
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_reg <= cur_next;
            if (cfg_we && cfg_index == CFG_ARENA)
                arena_reg <= arena_val;
            if (cfg_we && cfg_index == CFG_POLICY)
                policy_reg <= cfg_data[1:0];

            if (cmd.code == CMD_START)
                sp_reg <= '0;
            else if (!stat.spare_done)
                sp_reg <= sp_reg + LW'(1);

            if (init_go)
            begin
                valid_reg    <= {{(TABLE_ENTRIES-1){1'b0}}, 1'b1};
                head_reg     <= '0;
                rover_reg    <= '0;
                count_reg    <= LW'(1);
            end
            else
            begin
                unique case (cmd.code)
                    CMD_EXACT:
                    begin
                        if (policy_reg == POL_NEXT)
                            rover_reg <= h_idx_reg;
                    end
                    CMD_SPLIT_N:
                    begin
                        valid_reg[sp_reg[IW-1:0]] <= 1'b1;
                        count_reg <= count_reg + LW'(1);
                    end
                    CMD_SPLIT_H:
                    begin
                        if (h_pred_reg >= NONE)
                            head_reg <= sp_reg;
                        if (policy_reg == POL_NEXT)
                            rover_reg <= h_idx_reg;
                    end
                    CMD_EV_NX:
                    begin
                        if (rd_hole_reg)
                        begin
                            valid_reg[cur_reg[IW-1:0]] <= 1'b0;
                            count_reg <= count_reg - LW'(1);
                            if (rover_reg == cur_reg)
                                rover_reg <= e_idx_reg;
                        end
                    end
                    CMD_EV_PV:
                    begin
                        if (rd_hole_reg)
                        begin
                            valid_reg[e_idx_reg[IW-1:0]] <= 1'b0;
                            count_reg <= count_reg - LW'(1);
                            if (rover_reg == e_idx_reg)
                                rover_reg <= cur_reg;
                        end
                    end
                    default:
                    begin
                        count_reg <= count_reg;
                    end
                endcase
            end

            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_grant  = out_grant_reg;
    assign out_count  = out_count_reg;

endmodule

`default_nettype wire

>>> hw/rtl/sgalloc_ctrl.sv
// ----------------------------------------------------------------------------
// Segment allocator controller
// Sequences the table scan, the split or merge updates and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module sgalloc_ctrl
    import sgalloc_pkg::*;
(
    input  wire      clk,
    input  wire      rst_n,
    input  wire      in_valid,
    output logic     in_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [4:0] S_INIT  = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_DISP  = 5'd2;
    localparam logic [4:0] S_ACHK  = 5'd3;
    localparam logic [4:0] S_AEV   = 5'd4;
    localparam logic [4:0] S_PICK  = 5'd5;
    localparam logic [4:0] S_EXACT = 5'd6;
    localparam logic [4:0] S_SPLN  = 5'd7;
    localparam logic [4:0] S_SPLH  = 5'd8;
    localparam logic [4:0] S_FCHK  = 5'd9;
    localparam logic [4:0] S_FEV   = 5'd10;
    localparam logic [4:0] S_MARK  = 5'd11;
    localparam logic [4:0] S_NCHK  = 5'd12;
    localparam logic [4:0] S_NEV   = 5'd13;
    localparam logic [4:0] S_PCHK  = 5'd14;
    localparam logic [4:0] S_PEV   = 5'd15;
    localparam logic [4:0] S_FIN   = 5'd16;

    logic [4:0]   state_reg, state_next;
    status_code_t res_reg, res_next;

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        cmd.code   = CMD_NONE;
        cmd.result = res_reg;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.code   = CMD_INIT;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.code   = CMD_START;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                priority if (stat.is_free)
                    state_next = S_FCHK;
                else if (stat.size_zero)
                begin
                    res_next   = ST_ZERO;
                    state_next = S_FIN;
                end
                else
                    state_next = S_ACHK;
            end
            S_ACHK:
            begin
                state_next = stat.scan_go ? S_AEV : S_PICK;
            end
            S_AEV:
            begin
                cmd.code   = CMD_EV_ALLOC;
                state_next = stat.ev_stop ? S_PICK : S_ACHK;
            end
            S_PICK:
            begin
                priority if (!stat.found)
                begin
                    res_next   = ST_NO_FIT;
                    state_next = S_FIN;
                end
                else if (stat.exact)
                    state_next = S_EXACT;
                else if (!stat.spare_done)
                    state_next = S_PICK;
                else if (stat.spare_none)
                begin
                    res_next   = ST_FULL;
                    state_next = S_FIN;
                end
                else
                    state_next = S_SPLN;
            end
            S_EXACT:
            begin
                cmd.code   = CMD_EXACT;
                res_next   = ST_OK;
                state_next = S_FIN;
            end
            S_SPLN:
            begin
                cmd.code   = CMD_SPLIT_N;
                state_next = S_SPLH;
            end
            S_SPLH:
            begin
                cmd.code   = CMD_SPLIT_H;
                res_next   = ST_OK;
                state_next = S_FIN;
            end
            S_FCHK:
            begin
                if (stat.idx_in_range)
                    state_next = S_FEV;
                else
                begin
                    res_next   = ST_NOT_FOUND;
                    state_next = S_FIN;
                end
            end
            S_FEV:
            begin
                cmd.code   = CMD_EV_FREE;
                state_next = stat.free_match ? S_MARK : S_FCHK;
            end
            S_MARK:
            begin
                cmd.code   = CMD_MARK;
                state_next = S_NCHK;
            end
            S_NCHK:
            begin
                if (stat.link_live)
                    state_next = S_NEV;
                else
                begin
                    cmd.code   = CMD_LOAD_PV;
                    state_next = S_PCHK;
                end
            end
            S_NEV:
            begin
                cmd.code   = CMD_EV_NX;
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                res_next = ST_OK;
                state_next = stat.link_live ? S_PEV : S_FIN;
            end
            S_PEV:
            begin
                cmd.code   = CMD_EV_PV;
                res_next   = ST_OK;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_ready)
                begin
                    cmd.code   = CMD_RESULT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            res_reg   <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

`default_nettype wire

>>> test/tb_segment_allocator_fit_policies_top.sv
// ----------------------------------------------------------------------------
// Segment allocator testbench
// Drives allocate and free words through the segment allocator under several
// arena sizes and every placement policy. A behavioural copy of the segment
// table predicts each output word, which is compared field by field. The
// sender works in bursts, the receiver stalls on its own pattern, and one long
// receiver hold-off fills the block so that it stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_segment_allocator_fit_policies_top
    import sgalloc_pkg::*;
();

    localparam int ENTRIES = 64;
    localparam int NONE    = ENTRIES;

    typedef struct packed {
        logic         op;
        logic [23:0]  req_bytes;
        logic [23:0]  release_offset;
    } request_t;

    typedef struct packed {
        status_code_t status;
        logic [23:0]  grant_offset;
        logic [6:0]   entries_in_use;
    } outcome_t;

    typedef struct {
        request_t req;
        logic     typed;
        outcome_t want;
    } vector_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        op;
    logic [23:0] req_bytes;
    logic [23:0] release_offset;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [23:0] grant_offset;
    logic [6:0]  entries_in_use;
    logic        cfg_we;
    logic        cfg_index;
    logic [23:0] cfg_data;

    segment_allocator_fit_policies_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .req_bytes      (req_bytes),
        .release_offset (release_offset),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .grant_offset   (grant_offset),
        .entries_in_use (entries_in_use),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // Shadow copy of the segment table.
    logic [24:0] arena_size;
    logic [1:0]  policy;
    logic [24:0] seg_len   [ENTRIES];
    logic [23:0] seg_base  [ENTRIES];
    int          seg_next  [ENTRIES];
    int          seg_prev  [ENTRIES];
    logic        seg_hole  [ENTRIES];
    logic        seg_used  [ENTRIES];
    int          head;
    int          rover;

    outcome_t    pending_words[$];
    int          errors;
    int          words_seen;
    logic        hold_off;
    logic [23:0] granted[$];

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #50ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t: %s got %0h expected %0h", $time, what, got, want);
        errors++;
    endtask

    function automatic void clear_table();
        for (int i = 0; i < ENTRIES; i++)
        begin
            seg_len[i]  = '0;
            seg_base[i] = '0;
            seg_next[i] = NONE;
            seg_prev[i] = NONE;
            seg_hole[i] = 1'b1;
            seg_used[i] = 1'b0;
        end
        seg_len[0]  = arena_size;
        seg_used[0] = 1'b1;
        head  = 0;
        rover = 0;
    endfunction

    function automatic logic is_live(int e);
        return e < ENTRIES && seg_used[e];
    endfunction

    function automatic logic hole_fits(int e, logic [24:0] size);
        return is_live(e) && seg_hole[e] && seg_len[e] >= size;
    endfunction

    function automatic void merge_into(int a, int b);
        int nx;
        nx = seg_next[b];
        seg_len[a]  = seg_len[a] + seg_len[b];
        seg_next[a] = nx;
        if (nx < ENTRIES)
            seg_prev[nx] = a;
        seg_used[b] = 1'b0;
        seg_len[b]  = '0;
        seg_next[b] = NONE;
        seg_prev[b] = NONE;
        if (rover == b)
            rover = a;
    endfunction

    function automatic int choose_hole(logic [24:0] size);
        int cur;
        int s;
        int nx;
        int pick;
        pick = NONE;
        if (policy == POL_NEXT)
        begin
            s = is_live(rover) ? rover : head;
            cur = s;
            for (int k = 0; k < ENTRIES && is_live(cur); k++)
            begin
                if (hole_fits(cur, size))
                    return cur;
                nx = seg_next[cur];
                if (nx >= ENTRIES)
                    nx = head;
                if (nx == s)
                    break;
                cur = nx;
            end
            return NONE;
        end
        cur = head;
        for (int k = 0; k < ENTRIES && is_live(cur); k++)
        begin
            if (hole_fits(cur, size))
            begin
                if (policy == POL_FIRST)
                    return cur;
                if (pick == NONE ||
                    (policy == POL_BEST && seg_len[cur] < seg_len[pick]) ||
                    (policy == POL_WORST && seg_len[cur] > seg_len[pick]))
                    pick = cur;
            end
            cur = seg_next[cur];
        end
        return pick;
    endfunction

    function automatic outcome_t predict_outcome(request_t r);
        outcome_t    o;
        logic [24:0] size;
        int          h;
        int          n;
        int          p;
        int          e;
        int          cnt;
        o = '0;
        if (r.op == OP_ALLOC)
        begin
            size = ({1'b0, r.req_bytes} + 25'd3) & ~25'd3;
            if (size == 0)
                o.status = ST_ZERO;
            else
            begin
                h = choose_hole(size);
                if (h == NONE)
                    o.status = ST_NO_FIT;
                else if (seg_len[h] == size)
                begin
                    seg_hole[h] = 1'b0;
                    o.grant_offset = seg_base[h];
                    if (policy == POL_NEXT)
                        rover = h;
                end
                else
                begin
                    n = NONE;
                    for (int i = ENTRIES - 1; i >= 0; i--)
                        if (!seg_used[i])
                            n = i;
                    if (n == NONE)
                        o.status = ST_FULL;
                    else
                    begin
                        p = seg_prev[h];
                        seg_used[n] = 1'b1;
                        seg_hole[n] = 1'b0;
                        seg_base[n] = seg_base[h];
                        seg_len[n]  = size;
                        seg_prev[n] = p;
                        seg_next[n] = h;
                        if (p < ENTRIES)
                            seg_next[p] = n;
                        else
                            head = n;
                        seg_prev[h] = n;
                        seg_base[h] = seg_base[h] + size[23:0];
                        seg_len[h]  = seg_len[h] - size;
                        o.grant_offset = seg_base[n];
                        if (policy == POL_NEXT)
                            rover = h;
                    end
                end
            end
        end
        else
        begin
            e = NONE;
            for (int i = ENTRIES - 1; i >= 0; i--)
                if (seg_used[i] && !seg_hole[i] && seg_base[i] == r.release_offset)
                    e = i;
            if (e == NONE)
                o.status = ST_NOT_FOUND;
            else
            begin
                seg_hole[e] = 1'b1;
                if (is_live(seg_next[e]) && seg_hole[seg_next[e]])
                    merge_into(e, seg_next[e]);
                p = seg_prev[e];
                if (is_live(p) && seg_hole[p])
                    merge_into(p, e);
            end
        end
        cnt = 0;
        for (int i = 0; i < ENTRIES; i++)
            if (seg_used[i])
                cnt++;
        o.entries_in_use = cnt[6:0];
        return o;
    endfunction

    task automatic write_register(input logic idx, input logic [23:0] value);
        logic [24:0] v;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_ARENA)
        begin
            v = ({1'b0, value} + 25'd3) & ~25'd3;
            if (v > 25'hFFFFFC)
                v = 25'hFFFFFC;
            arena_size = v;
            clear_table();
            granted.delete();
        end
        else
            policy = value[1:0];
        @(posedge clk);
    endtask

    task automatic send_word(input request_t r, input logic typed, input outcome_t want);
        outcome_t o;
        in_valid       <= 1'b1;
        op             <= r.op;
        req_bytes      <= r.req_bytes;
        release_offset <= r.release_offset;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        o = predict_outcome(r);
        if (typed)
        begin
            if (o.status != want.status)
                report("typed status", 32'(o.status), 32'(want.status));
            if (o.grant_offset != want.grant_offset)
                report("typed grant_offset", 32'(o.grant_offset), 32'(want.grant_offset));
            if (o.entries_in_use != want.entries_in_use)
                report("typed entries_in_use", 32'(o.entries_in_use),
                       32'(want.entries_in_use));
        end
        if (r.op == OP_ALLOC && o.status == ST_OK)
            granted.push_back(o.grant_offset);
        pending_words.push_back(o);
        if ($urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (2 * ENTRIES + 20)
            @(posedge clk);
    endtask

    function automatic request_t random_request(int scale);
        request_t r;
        int       k;
        r.op = ($urandom_range(0, 99) < 55) ? OP_ALLOC : OP_FREE;
        r.req_bytes = 24'($urandom_range(0, scale));
        r.release_offset = 24'($urandom);
        if ($urandom_range(0, 19) == 0)
            r.req_bytes = 24'($urandom);
        if (r.op == OP_FREE && granted.size() != 0 && $urandom_range(0, 9) != 0)
        begin
            k = int'($urandom_range(0, granted.size() - 1));
            r.release_offset = granted[k];
            granted.delete(k);
        end
        return r;
    endfunction

    // Receiver: stalls at random, with one long hold-off on request.
    initial
    begin
        out_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (400)
                    @(posedge clk);
                hold_off = 1'b0;
                out_stall <= 1'b0;
            end
            else if (words_seen % 64 < 24)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 2) == 0);
        end
    end

    always @(posedge clk)
    begin
        outcome_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            words_seen++;
            if (pending_words.size() == 0)
                report("unexpected word", 32'(status), 32'd0);
            else
            begin
                w = pending_words.pop_front();
                if (status != w.status)
                    report("status", 32'(status), 32'(w.status));
                if (grant_offset != w.grant_offset)
                    report("grant_offset", 32'(grant_offset), 32'(w.grant_offset));
                if (entries_in_use != w.entries_in_use)
                    report("entries_in_use", 32'(entries_in_use), 32'(w.entries_in_use));
            end
        end
    end

    initial
    begin
        vector_t  rows[$];
        request_t r;
        int       scale;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_ALLOC;
        req_bytes = '0;
        release_offset = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_ARENA;
        cfg_data = '0;
        errors = 0;
        words_seen = 0;
        hold_off = 1'b0;
        arena_size = 25'd4096;
        policy = POL_FIRST;
        clear_table();
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows = '{
            '{'{OP_ALLOC, 24'd0, 24'd0},        1'b1, '{ST_ZERO, 24'd0, 7'd1}},
            '{'{OP_ALLOC, 24'hFFFFFF, 24'd0},   1'b1, '{ST_NO_FIT, 24'd0, 7'd1}},
            '{'{OP_FREE, 24'd0, 24'd0},         1'b1, '{ST_NOT_FOUND, 24'd0, 7'd1}},
            '{'{OP_ALLOC, 24'd1, 24'd0},        1'b1, '{ST_OK, 24'd0, 7'd2}},
            '{'{OP_ALLOC, 24'd5, 24'd0},        1'b1, '{ST_OK, 24'd4, 7'd3}},
            '{'{OP_ALLOC, 24'd100, 24'd0},      1'b0, '{ST_OK, 24'd0, 7'd0}},
            '{'{OP_FREE, 24'd0, 24'd4},         1'b0, '{ST_OK, 24'd0, 7'd0}},
            '{'{OP_FREE, 24'd0, 24'hFFFFFF},    1'b1, '{ST_NOT_FOUND, 24'd0, 7'd4}},
            '{'{OP_ALLOC, 24'd4, 24'd0},        1'b0, '{ST_OK, 24'd0, 7'd0}},
            '{'{OP_FREE, 24'd0, 24'd0},         1'b0, '{ST_OK, 24'd0, 7'd0}},
            '{'{OP_ALLOC, 24'd3980, 24'd0},     1'b0, '{ST_OK, 24'd0, 7'd0}},
            '{'{OP_ALLOC, 24'd200, 24'd0},      1'b0, '{ST_OK, 24'd0, 7'd0}},
            '{'{OP_FREE, 24'd0, 24'd12},        1'b0, '{ST_OK, 24'd0, 7'd0}}
        };
        foreach (rows[i])
            send_word(rows[i].req, rows[i].typed, rows[i].want);
        in_valid <= 1'b0;
        wait_idle();

        // Zero arena fits nothing; the largest arena saturates.
        write_register(CFG_ARENA, 24'd0);
        send_word('{OP_ALLOC, 24'd4, 24'd0}, 1'b1, '{ST_NO_FIT, 24'd0, 7'd1});
        in_valid <= 1'b0;
        wait_idle();
        write_register(CFG_ARENA, 24'hFFFFFF);
        send_word('{OP_ALLOC, 24'hFFFFFC, 24'd0}, 1'b1, '{ST_OK, 24'd0, 7'd1});
        send_word('{OP_FREE, 24'd0, 24'd0}, 1'b0, '{ST_OK, 24'd0, 7'd0});
        in_valid <= 1'b0;
        wait_idle();

        for (int phase = 0; phase < 8; phase++)
        begin
            write_register(CFG_POLICY, phase[1:0]);
            case (phase)
                0: write_register(CFG_ARENA, 24'd4096);
                2: write_register(CFG_ARENA, 24'd1023);
                4: write_register(CFG_ARENA, 24'hFFFFFF);
                6: write_register(CFG_ARENA, 24'd600);
                default: ;
            endcase
            scale = (phase == 4) ? 24'hFFFFFF : 96;
            if (phase == 3)
                hold_off = 1'b1;
            // Phase five runs mostly allocations to fill the table.
            for (int n = 0; n < 56; n++)
            begin
                r = random_request(scale);
                if (phase == 5 && $urandom_range(0, 3) != 0)
                    r.op = OP_ALLOC;
                if (phase == 5)
                    r.req_bytes = 24'($urandom_range(1, 8));
                send_word(r, 1'b0, '0);
            end
            in_valid <= 1'b0;
            wait_idle();
        end
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
